/* design/ffa_pkg.sv */
// Shared types and constants of the first-fit allocator.
`timescale 1ns / 1ps
`default_nettype none
package ffa_pkg;
  localparam int unsigned MaxBlocksDefault = 16;
  localparam logic [15:0] MemSizeReset     = 16'hFFFF;

  typedef enum logic [1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_DEALLOC = 2'd1,
    CMD_COMPACT = 2'd2,
    CMD_NOP     = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_GAP  = 2'd1,
    ST_UNKNOWN = 2'd2,
    ST_FULL    = 2'd3
  } status_e;

  // One table entry as held in memory.
  typedef struct packed {
    logic [15:0] owner;
    logic [15:0] size;
    logic [15:0] start;
  } entry_t;
endpackage
`default_nettype wire

/* design/ffa_table.sv */
// Entry table memory: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module ffa_table #(
  parameter int unsigned Depth = 16,
  parameter int unsigned AW    = 4
) (
  input  wire                  clk_i,
  input  wire                  we_i,
  input  wire  [AW-1:0]        waddr_i,
  input  wire  ffa_pkg::entry_t wdata_i,
  input  wire  [AW-1:0]        raddr_i,
  output ffa_pkg::entry_t      rdata_o
);
  import ffa_pkg::*;

  entry_t mem_q [Depth];
  entry_t rdata_q;

  // Write and read the store
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule
`default_nettype wire

/* design/first_fit_allocator_top.sv */
// Top level of the first-fit allocator: command sequencer around the table.
//
// Usage: pulse start with command_i, block_owner_i and request_size_i while
// busy is low. Exactly one result follows: done_o is high for one cycle
// with status_o and start_address_o; the receiver cannot stall it.
// memory_size is written through cfg_we_i / cfg_data_i; the user must write it
// only while idle, the block itself does not enforce this.
// Allocate, deallocate and compact read the table memory (one write port,
// one registered read port) in order, one read per cycle; an insert or a
// remove then moves entries one at a time, each by a read, a wait state for
// the registered read data and a write. A table-full allocate, a deallocate
// on an empty table and the unused command answer in the cycle after
// acceptance. The worst-case command time is set by the entry moves. busy
// stays high from acceptance through the cycle with done_o.
// Reset empties the table (entry count to zero) and sets memory_size to
// 65535; the memory content needs no clearing.
`timescale 1ns / 1ps
`default_nettype none
module first_fit_allocator_top #(
  parameter int unsigned MaxBlocks = ffa_pkg::MaxBlocksDefault
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         start,
  output logic        busy,
  input  wire  [1:0]  command_i,
  input  wire  [15:0] block_owner_i,
  input  wire  [15:0] request_size_i,
  input  wire         cfg_we_i,
  input  wire  [15:0] cfg_data_i,
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic [15:0] start_address_o
);
  import ffa_pkg::*;

  localparam int unsigned AW = (MaxBlocks > 1) ? $clog2(MaxBlocks) : 1;
  localparam int unsigned CW = $clog2(MaxBlocks + 1);
  localparam logic [CW-1:0] CntMax = CW'(MaxBlocks);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_SCAN  = 8'b0000_0010,  // read entries in order, evaluate
    S_SHUP  = 8'b0000_0100,  // move entries up (insert)
    S_INS   = 8'b0000_1000,  // write new entry
    S_SHDN  = 8'b0001_0000,  // move entries down (remove)
    S_CMP   = 8'b0010_0000,  // compact rewrite
    S_DONE  = 8'b0100_0000,
    S_WAIT  = 8'b1000_0000   // read latency bubble in shifts
  } state_e;

  state_e      state_q, state_d;
  logic [15:0] mem_size_q;
  logic [CW-1:0] count_q, count_d;
  logic [1:0]  cmd_q;
  logic [15:0] owner_q, size_q;
  logic [CW-1:0] idx_q, idx_d;     // index being read / walked
  logic        rvalid_q, rvalid_d; // read data for idx_q-1 is present
  logic [CW-1:0] pos_q, pos_d;     // insert or remove position
  logic [16:0] prev_end_q, prev_end_d;
  logic [1:0]  st_q, st_d;
  logic [15:0] addr_q, addr_d;
  logic        shift_rd_q, shift_rd_d;

  logic        we;
  logic [AW-1:0] waddr, raddr;
  entry_t      wdata, rdata;

  ffa_table #(.Depth(MaxBlocks), .AW(AW)) u_table (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign busy = (state_q != S_IDLE);
  wire accept = start && !busy;

  // Entry at idx_q-1 has arrived from memory
  wire [CW-1:0] ridx  = idx_q - CW'(1);
  wire [16:0]   r_end = {1'b0, rdata.start} + {1'b0, rdata.size};
  wire [16:0]   gap_lo = ({1'b0, rdata.start} > prev_end_q) ?
                         ({1'b0, rdata.start} - prev_end_q) : 17'd0;
  // End of the last entry seen, including the one arriving this cycle
  wire [16:0]   tail_end = rvalid_q ? r_end : prev_end_q;
  wire [16:0]   gap_hi = ({1'b0, mem_size_q} > tail_end) ?
                         ({1'b0, mem_size_q} - tail_end) : 17'd0;

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    idx_d      = idx_q;
    rvalid_d   = 1'b0;
    pos_d      = pos_q;
    prev_end_d = prev_end_q;
    st_d       = st_q;
    addr_d     = addr_q;
    shift_rd_d = shift_rd_q;
    we         = 1'b0;
    waddr      = idx_q[AW-1:0];
    wdata      = rdata;
    raddr      = idx_q[AW-1:0];

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          idx_d      = '0;
          prev_end_d = '0;
          st_d       = ST_OK;
          addr_d     = '0;
          case (cmd_e'(command_i))
            CMD_ALLOC: begin
              if (count_q == CntMax) begin
                st_d    = ST_FULL;
                state_d = S_DONE;
              end else begin
                state_d = S_SCAN;
              end
            end
            CMD_DEALLOC: state_d = S_SCAN;
            CMD_COMPACT: state_d = S_CMP;
            default:     state_d = S_DONE;
          endcase
          if (count_q == '0 && command_i == CMD_DEALLOC) begin
            st_d    = ST_UNKNOWN;
            state_d = S_DONE;
          end
        end
      end

      S_SCAN: begin
        // Issue next read, evaluate data of previous read
        raddr    = idx_q[AW-1:0];
        rvalid_d = (idx_q < count_q);
        idx_d    = idx_q + CW'(1);
        if (rvalid_q) begin
          if (cmd_q == CMD_ALLOC) begin
            if ({1'b0, size_q} <= gap_lo) begin
              pos_d   = ridx;
              addr_d  = prev_end_q[15:0];
              state_d = S_SHUP;
              idx_d   = count_q;
            end else begin
              prev_end_d = r_end;
            end
          end else if (rdata.owner == owner_q) begin
            pos_d   = ridx;
            idx_d   = ridx + CW'(1);
            state_d = S_SHDN;
          end
        end
        if (state_d == S_SCAN && !rvalid_d && (rvalid_q || idx_q != '0 ||
            count_q == '0)) begin
          // Ran off the end
          if (cmd_q == CMD_ALLOC) begin
            if ({1'b0, size_q} <= gap_hi) begin
              pos_d   = count_q;
              addr_d  = tail_end[15:0];
              state_d = S_INS;
            end else begin
              st_d    = ST_NO_GAP;
              state_d = S_DONE;
            end
          end else begin
            st_d    = ST_UNKNOWN;
            state_d = S_DONE;
          end
        end
        if (state_d == S_SHUP) begin
          shift_rd_d = 1'b0;
        end
      end

      S_SHUP: begin
        // Move entry idx-1 to idx, from the top down
        if (idx_q == pos_q) begin
          state_d = S_INS;
        end else if (!shift_rd_q) begin
          raddr      = ridx[AW-1:0];
          shift_rd_d = 1'b1;
          state_d    = S_WAIT;
        end else begin
          we         = 1'b1;
          waddr      = idx_q[AW-1:0];
          idx_d      = ridx;
          shift_rd_d = 1'b0;
        end
      end

      S_WAIT: begin
        // Hold the read address so the data survives the bubble
        raddr   = (cmd_q == CMD_ALLOC) ? ridx[AW-1:0] : idx_q[AW-1:0];
        state_d = (cmd_q == CMD_ALLOC) ? S_SHUP : S_SHDN;
      end

      S_INS: begin
        we          = 1'b1;
        waddr       = pos_q[AW-1:0];
        wdata.owner = owner_q;
        wdata.size  = size_q;
        wdata.start = addr_q;
        count_d     = count_q + CW'(1);
        state_d     = S_DONE;
      end

      S_SHDN: begin
        // Move entry idx to idx-1 while idx < count
        if (idx_q >= count_q) begin
          count_d = count_q - CW'(1);
          state_d = S_DONE;
        end else if (!shift_rd_q) begin
          raddr      = idx_q[AW-1:0];
          shift_rd_d = 1'b1;
          state_d    = S_WAIT;
        end else begin
          we         = 1'b1;
          waddr      = ridx[AW-1:0];
          idx_d      = idx_q + CW'(1);
          shift_rd_d = 1'b0;
        end
      end

      S_CMP: begin
        // Read entry idx, rewrite entry idx-1 with packed start
        raddr    = idx_q[AW-1:0];
        rvalid_d = (idx_q < count_q);
        idx_d    = idx_q + CW'(1);
        if (rvalid_q) begin
          we          = 1'b1;
          waddr       = ridx[AW-1:0];
          wdata.start = prev_end_q[15:0];
          prev_end_d  = prev_end_q + {1'b0, rdata.size};
        end
        if (!rvalid_d && (rvalid_q || count_q == '0)) begin
          addr_d  = rvalid_q ? prev_end_d[15:0] : 16'd0;
          state_d = S_DONE;
        end
      end

      S_DONE: state_d = S_IDLE;

      default: state_d = S_IDLE;
    endcase
  end

  // Advance control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      count_q    <= '0;
      mem_size_q <= MemSizeReset;
      rvalid_q   <= 1'b0;
      shift_rd_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      rvalid_q   <= rvalid_d;
      shift_rd_q <= shift_rd_d;
      if (cfg_we_i) begin
        mem_size_q <= cfg_data_i;
      end
    end
  end

  // Hold transaction payload and working values
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q   <= command_i;
      owner_q <= block_owner_i;
      size_q  <= request_size_i;
    end
    idx_q      <= idx_d;
    pos_q      <= pos_d;
    prev_end_q <= prev_end_d;
    st_q       <= st_d;
    addr_q     <= addr_d;
  end

  assign done_o          = (state_q == S_DONE);
  assign status_o        = st_q;
  assign start_address_o = (st_q == ST_OK) ? addr_q : 16'd0;
endmodule
`default_nettype wire

/* tb/first_fit_allocator_top_test.sv */
// Self-checking testbench of the first-fit allocator: directed and random commands.
`timescale 1ns / 1ps
`default_nettype none

// Tracks the allocation table and holds the expected answers in order.
class alloc_table_tracker;
  int unsigned mem_size;
  logic [15:0] own_q[$];
  logic [15:0] size_q[$];
  logic [15:0] base_q[$];
  logic [1:0]  exp_status_q[$];
  logic [15:0] exp_addr_q[$];
  int errors;

  function void clear();
    mem_size = 65535;
    own_q = {};
    size_q = {};
    base_q = {};
    exp_status_q = {};
    exp_addr_q = {};
    errors = 0;
  endfunction

  function int unsigned entries();
    return own_q.size();
  endfunction

  // Note an accepted command and work out its answer.
  function void note_command(ffa_pkg::cmd_e cmd, logic [15:0] owner, logic [15:0] req);
    ffa_pkg::status_e st;
    logic [15:0] addr;
    int unsigned n;
    int unsigned nxt;
    int unsigned gap;
    int unsigned e;
    int pos;
    st = ffa_pkg::ST_OK;
    addr = '0;
    n = own_q.size();
    pos = -1;
    case (cmd)
      ffa_pkg::CMD_ALLOC: begin
        if (n >= 16) begin
          st = ffa_pkg::ST_FULL;
        end else if (n == 0) begin
          if (req > mem_size) st = ffa_pkg::ST_NO_GAP;
          else pos = 0;
        end else if (req <= base_q[0]) begin
          pos = 0;
        end else begin
          for (int i = 0; i + 1 < n && pos < 0; i++) begin
            e = base_q[i] + size_q[i];
            gap = (base_q[i+1] > e) ? base_q[i+1] - e : 0;
            if (req <= gap) begin
              pos = i + 1;
              addr = e[15:0];
            end
          end
          if (pos < 0) begin
            e = base_q[n-1] + size_q[n-1];
            gap = (mem_size > e) ? mem_size - e : 0;
            if (req <= gap) begin
              pos = n;
              addr = e[15:0];
            end else begin
              st = ffa_pkg::ST_NO_GAP;
            end
          end
        end
        if (pos >= 0) begin
          own_q.insert(pos, owner);
          size_q.insert(pos, req);
          base_q.insert(pos, addr);
        end
      end
      ffa_pkg::CMD_DEALLOC: begin
        st = ffa_pkg::ST_UNKNOWN;
        for (int i = 0; i < n && st != ffa_pkg::ST_OK; i++) begin
          if (own_q[i] == owner) begin
            own_q.delete(i);
            size_q.delete(i);
            base_q.delete(i);
            st = ffa_pkg::ST_OK;
          end
        end
      end
      ffa_pkg::CMD_COMPACT: begin
        nxt = 0;
        for (int i = 0; i < n; i++) begin
          base_q[i] = nxt[15:0];
          nxt = (nxt + size_q[i]) & 32'h1FFFF;
        end
        addr = nxt[15:0];
      end
      default: ;
    endcase
    exp_status_q.push_back(st);
    exp_addr_q.push_back(addr);
  endfunction

  // Compare one answer with the oldest expectation.
  function void check_answer(logic [1:0] st, logic [15:0] addr);
    if (exp_status_q.size() == 0) begin
      $display("%0t: unexpected answer status=%0d addr=%0d", $time, st, addr);
      errors++;
      return;
    end
    if (st !== exp_status_q[0]) begin
      $display("%0t: status expected %0d actual %0d", $time, exp_status_q[0], st);
      errors++;
    end
    if (addr !== exp_addr_q[0]) begin
      $display("%0t: start_address expected %0d actual %0d", $time, exp_addr_q[0], addr);
      errors++;
    end
    void'(exp_status_q.pop_front());
    void'(exp_addr_q.pop_front());
  endfunction

  function int unsigned pending();
    return exp_status_q.size();
  endfunction
endclass

module first_fit_allocator_top_test;
  import ffa_pkg::*;

  localparam int unsigned StallLimit = 5000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  command_i = '0;
  logic [15:0] block_owner_i = '0;
  logic [15:0] request_size_i = '0;
  logic        cfg_we_i = 1'b0;
  logic [15:0] cfg_data_i = '0;
  logic        done_o;
  logic [1:0]  status_o;
  logic [15:0] start_address_o;

  alloc_table_tracker tracker;
  int unsigned idle_cycles;
  logic [15:0] recent_owner;

  first_fit_allocator_top dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .command_i(command_i), .block_owner_i(block_owner_i),
    .request_size_i(request_size_i), .cfg_we_i(cfg_we_i), .cfg_data_i(cfg_data_i),
    .done_o(done_o), .status_o(status_o), .start_address_o(start_address_o)
  );

  always #5 clk_i = ~clk_i;

  // Check answers and count cycles with no transaction.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) tracker.check_answer(status_o, start_address_o);
      if (done_o || (start && !busy)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > StallLimit) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  task automatic idle_gap();
    int unsigned g;
    g = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 60) : $urandom_range(0, 2);
    repeat (g) @(negedge clk_i);
  endtask

  // Issue one command and hold it until accepted.
  task automatic issue(cmd_e cmd, logic [15:0] owner, logic [15:0] req, bit gaps = 1);
    start <= 1'b1;
    command_i <= cmd;
    block_owner_i <= owner;
    request_size_i <= req;
    do @(posedge clk_i); while (busy);
    tracker.note_command(cmd, owner, req);
    @(negedge clk_i);
    start <= 1'b0;
    @(negedge clk_i);
    if (gaps && $urandom_range(0, 2) == 0) idle_gap();
  endtask

  task automatic drain();
    while (tracker.pending() != 0) @(negedge clk_i);
    repeat (50) @(negedge clk_i);
  endtask

  task automatic set_memory_size(logic [15:0] val);
    drain();
    cfg_we_i <= 1'b1;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    tracker.mem_size = val;
  endtask

  function automatic logic [15:0] pick_size(int unsigned mode);
    case ($urandom_range(0, 7))
      0: return 16'(0);
      1: return 16'hFFFF;
      2, 3: return 16'($urandom_range(0, 65535));
      default: return 16'($urandom_range(1, (mode > 0) ? mode : 1));
    endcase
  endfunction

  task automatic random_phase(int unsigned count, int unsigned unit);
    int unsigned r;
    logic [15:0] own;
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(0, 99);
      own = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 7));
      if (r < 50) begin
        issue(CMD_ALLOC, own, pick_size(unit));
        recent_owner = own;
      end else if (r < 85) begin
        issue(CMD_DEALLOC, ($urandom_range(0, 1) != 0) ? recent_owner : own, 16'($urandom));
      end else if (r < 97) begin
        issue(CMD_COMPACT, 16'($urandom), 16'($urandom));
      end else begin
        issue(CMD_NOP, 16'($urandom), 16'($urandom));
      end
    end
  endtask

  initial begin
    tracker = new();
    tracker.clear();
    idle_cycles = 0;
    recent_owner = '0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: empty-table cases, zero size, extremes, fill to table full.
    issue(CMD_DEALLOC, 16'h0001, 16'h0000, 0);
    issue(CMD_COMPACT, 16'hFFFF, 16'hFFFF, 0);
    issue(CMD_NOP, 16'hFFFF, 16'hFFFF, 0);
    issue(CMD_ALLOC, 16'hFFFF, 16'hFFFF, 0);
    issue(CMD_ALLOC, 16'h0000, 16'h0000, 0);
    issue(CMD_DEALLOC, 16'hFFFF, 16'h0000, 0);
    issue(CMD_ALLOC, 16'h0000, 16'h0000, 0);
    for (int k = 0; k < 16; k++) issue(CMD_ALLOC, 16'(k + 1), 16'(100 + k), 0);
    issue(CMD_DEALLOC, 16'h0003, 16'h0000, 0);
    issue(CMD_DEALLOC, 16'h0005, 16'h0000, 0);
    issue(CMD_ALLOC, 16'h0020, 16'h0050, 0);
    issue(CMD_COMPACT, 16'h0000, 16'h0000, 0);

    // Shrunk memory below the last block end.
    set_memory_size(16'd500);
    issue(CMD_ALLOC, 16'h0021, 16'h0001, 0);
    set_memory_size(16'd0);
    issue(CMD_COMPACT, 16'h0000, 16'h0000, 0);
    for (int k = 0; k < 20; k++) issue(CMD_DEALLOC, 16'(k), 16'h0000, 0);
    issue(CMD_ALLOC, 16'h0001, 16'h0000, 0);
    issue(CMD_ALLOC, 16'h0002, 16'h0001, 0);

    // Random phases over several memory sizes.
    set_memory_size(16'd4000);
    random_phase(300, 600);
    set_memory_size(16'hFFFF);
    random_phase(300, 8000);
    set_memory_size(16'd64);
    random_phase(200, 12);
    set_memory_size(16'($urandom));
    random_phase(300, 5000);

    drain();
    if (tracker.errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end
endmodule
`default_nettype wire

/* first_fit_allocator_top.f */
design/ffa_pkg.sv
design/ffa_table.sv
design/first_fit_allocator_top.sv
tb/first_fit_allocator_top_test.sv
